### hdl/sapb_pkg.sv
// shared types and constants for the stereo all-pass biquad cascade
package sapb_pkg;

    localparam int COEF_BITS = 24;
    localparam int COEF_FRAC = 22;
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_IDX_BITS = 2;
    localparam int STAGE_CNT_BITS = 4;
    localparam int TERM_BITS = 3;
    localparam int MAC_CNT_BITS = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_COEF_A0     = 2'd0,
        CFG_COEF_A1     = 2'd1,
        CFG_STAGE_COUNT = 2'd2
    } cfg_idx_t;

    // product selector within one channel
    localparam logic [1:0] TERM_X0 = 2'd0;
    localparam logic [1:0] TERM_X1 = 2'd1;
    localparam logic [1:0] TERM_Y1 = 2'd2;
    localparam logic [1:0] TERM_Y2 = 2'd3;

    typedef struct packed {
        logic                 load_in;
        logic                 rd_en;
        logic                 mac_init;
        logic                 mul_en;
        logic [TERM_BITS-1:0] term;
        logic                 acc_en;
        logic                 wr_en;
        logic                 out_load;
    } sapb_cmd_t;

    typedef struct packed {
        logic out_stall;
    } sapb_sts_t;

endpackage

### hdl/sapb_ctrl.sv
// sequencer for the all-pass cascade: stage loop and multiply schedule
module sapb_ctrl #(
    parameter int MAX_STAGES = 8,
    parameter int STG_W      = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [sapb_pkg::STAGE_CNT_BITS-1:0] stage_count,
    output logic [STG_W-1:0]                   stage_idx,
    output sapb_pkg::sapb_cmd_t                cmd,
    input  sapb_pkg::sapb_sts_t                sts
);
    import sapb_pkg::*;

    localparam int NW = 6;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_MAC   = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [STG_W-1:0]        stage_reg, stage_next;
    logic [MAC_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]           n_eff;
    logic                    last_stage;

    always_comb begin
        if (stage_count == '0) begin
            n_eff = NW'(1);
        end else if (NW'(stage_count) > NW'(MAX_STAGES)) begin
            n_eff = NW'(MAX_STAGES);
        end else begin
            n_eff = NW'(stage_count);
        end
    end

    assign last_stage = (NW'(stage_reg) == (n_eff - NW'(1)));
    assign s_ready    = (state_reg == ST_IDLE);
    assign stage_idx  = stage_reg;

    always_comb begin
        state_next   = state_reg;
        stage_next   = stage_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.term     = cnt_reg[TERM_BITS-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    stage_next  = '0;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                cnt_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                cmd.mac_init = (cnt_reg == '0);
                cmd.mul_en   = ~cnt_reg[MAC_CNT_BITS-1];
                cmd.acc_en   = (cnt_reg != '0);
                cnt_next     = cnt_reg + MAC_CNT_BITS'(1);
                if (cnt_reg[MAC_CNT_BITS-1]) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.wr_en = 1'b1;
                if (last_stage) begin
                    state_next = ST_DONE;
                end else begin
                    stage_next = stage_reg + STG_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                if (!sts.out_stall) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            stage_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            cnt_reg   <= cnt_next;
        end
    end

    // history write-back only after the last product has been summed
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> $past(cmd.acc_en) && !cmd.mul_en && !cmd.acc_en)
        else $error("history write not preceded by accumulate");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !sts.out_stall)
        else $error("result loaded over a waiting transaction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |=> cmd.mac_init && cmd.mul_en)
        else $error("multiply schedule did not follow history read");

endmodule

### hdl/sapb_dp.sv
// datapath: history rows, shared multiplier, accumulators, saturation, output register
module sapb_dp #(
    parameter int MAX_STAGES  = 8,
    parameter int SAMPLE_BITS = 24,
    parameter int STG_W       = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sapb_pkg::sapb_cmd_t                 cmd,
    output sapb_pkg::sapb_sts_t                 sts,
    input  logic [STG_W-1:0]                    stage_idx,
    input  logic signed [sapb_pkg::COEF_BITS-1:0] coef_a0,
    input  logic signed [sapb_pkg::COEF_BITS-1:0] coef_a1,
    input  logic signed [SAMPLE_BITS-1:0]       s_left_in,
    input  logic signed [SAMPLE_BITS-1:0]       s_right_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_left_out,
    output logic signed [SAMPLE_BITS-1:0]       m_right_out,
    output logic                                m_clipped
);
    import sapb_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = SB + COEF_BITS;
    localparam int AW    = PW + 2;
    localparam int ROW_W = 4 * SB;
    localparam int TOP_W = AW - COEF_FRAC - SB + 1;
    localparam logic signed [AW-1:0] ROUND_HALF =
        {{(AW-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};

    logic [ROW_W-1:0] left_mem  [MAX_STAGES];
    logic [ROW_W-1:0] right_mem [MAX_STAGES];
    logic [MAX_STAGES-1:0] row_valid_reg;

    logic [ROW_W-1:0] row_l_reg, row_r_reg;
    logic             rd_valid_reg;
    logic [ROW_W-1:0] row_l, row_r;

    logic signed [SB-1:0] x_l_reg, x_r_reg;
    logic                 clip_reg;
    logic signed [PW-1:0] prod_reg;
    logic                 prod_sub_reg, prod_ch_reg;
    logic signed [AW-1:0] acc_l_reg, acc_r_reg;

    logic signed [COEF_BITS-1:0] coef_sel;
    logic signed [SB-1:0]        op_sel;
    logic [ROW_W-1:0]            op_row;
    logic signed [PW-1:0]        prod_next;
    logic signed [AW-1:0]        addend;
    logic signed [SB-1:0]        y_l, y_r;
    logic                        clip_l, clip_r;

    logic                 m_valid_reg;
    logic signed [SB-1:0] left_out_reg, right_out_reg;
    logic                 clipped_reg;

    assign row_l = rd_valid_reg ? row_l_reg : '0;
    assign row_r = rd_valid_reg ? row_r_reg : '0;

    // history memories
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            left_mem[stage_idx]  <= {row_l[2*SB +: SB], y_l, row_l[0 +: SB], x_l_reg};
            right_mem[stage_idx] <= {row_r[2*SB +: SB], y_r, row_r[0 +: SB], x_r_reg};
        end
        if (cmd.rd_en) begin
            row_l_reg <= left_mem[stage_idx];
            row_r_reg <= right_mem[stage_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (cmd.wr_en) begin
                row_valid_reg[stage_idx] <= 1'b1;
            end
            if (cmd.rd_en) begin
                rd_valid_reg <= row_valid_reg[stage_idx];
            end
        end
    end

    // shared multiplier
    assign op_row = cmd.term[2] ? row_r : row_l;

    always_comb begin
        unique case (cmd.term[1:0])
            TERM_X0: begin
                coef_sel = coef_a0;
                op_sel   = cmd.term[2] ? x_r_reg : x_l_reg;
            end
            TERM_X1: begin
                coef_sel = coef_a1;
                op_sel   = op_row[0 +: SB];
            end
            TERM_Y1: begin
                coef_sel = coef_a1;
                op_sel   = op_row[2*SB +: SB];
            end
            TERM_Y2: begin
                coef_sel = coef_a0;
                op_sel   = op_row[3*SB +: SB];
            end
            default: begin
                coef_sel = coef_a0;
                op_sel   = x_l_reg;
            end
        endcase
    end

    assign prod_next = PW'(coef_sel) * PW'(op_sel);
    assign addend    = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg     <= prod_next;
            prod_sub_reg <= cmd.term[1];
            prod_ch_reg  <= cmd.term[2];
        end
    end

    // accumulators, seeded with the x2 term and the rounding constant
    always_ff @(posedge aclk) begin
        if (cmd.mac_init) begin
            acc_l_reg <= $signed({{(AW-SB-COEF_FRAC){row_l[2*SB-1]}}, row_l[SB +: SB],
                                  {COEF_FRAC{1'b0}}}) + ROUND_HALF;
            acc_r_reg <= $signed({{(AW-SB-COEF_FRAC){row_r[2*SB-1]}}, row_r[SB +: SB],
                                  {COEF_FRAC{1'b0}}}) + ROUND_HALF;
        end
        if (cmd.acc_en && !prod_ch_reg) begin
            acc_l_reg <= prod_sub_reg ? acc_l_reg - addend : acc_l_reg + addend;
        end
        if (cmd.acc_en && prod_ch_reg) begin
            acc_r_reg <= prod_sub_reg ? acc_r_reg - addend : acc_r_reg + addend;
        end
    end

    // floor by 2^22 then saturate
    always_comb begin
        clip_l = !((&acc_l_reg[AW-1 -: TOP_W]) || !(|acc_l_reg[AW-1 -: TOP_W]));
        clip_r = !((&acc_r_reg[AW-1 -: TOP_W]) || !(|acc_r_reg[AW-1 -: TOP_W]));
        if (clip_l) begin
            y_l = acc_l_reg[AW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end else begin
            y_l = acc_l_reg[COEF_FRAC +: SB];
        end
        if (clip_r) begin
            y_r = acc_r_reg[AW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end else begin
            y_r = acc_r_reg[COEF_FRAC +: SB];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_l_reg <= s_left_in;
            x_r_reg <= s_right_in;
        end else if (cmd.wr_en) begin
            x_l_reg <= y_l;
            x_r_reg <= y_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_reg <= 1'b0;
        end else if (cmd.load_in) begin
            clip_reg <= 1'b0;
        end else if (cmd.wr_en) begin
            clip_reg <= clip_reg | clip_l | clip_r;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            left_out_reg  <= x_l_reg;
            right_out_reg <= x_r_reg;
            clipped_reg   <= clip_reg;
        end
    end

    assign sts.out_stall = m_valid_reg & ~m_ready;
    assign m_valid       = m_valid_reg;
    assign m_left_out    = left_out_reg;
    assign m_right_out   = right_out_reg;
    assign m_clipped     = clipped_reg;

endmodule

### hdl/stereo_allpass_biquad_cascade.sv
// top level: configuration registers, sequencer and datapath of the all-pass cascade
//
// Each stereo pair runs through stage_count second-order all-pass sections
// (0 is taken as 1, values above MAX_STAGES as MAX_STAGES). Every section
// reads its history row, pushes eight products through the single shared
// multiplier at one per cycle with each accumulate in the cycle after its
// product, then rounds, saturates and writes the row back. One pair is in
// flight at a time; a new transaction is taken while the previous result
// still waits in the output register. History is zero after reset without a
// clearing pass; coefficient writes keep the history, and the user must make
// them between pairs so that they apply to the next pair: the block itself
// does not enforce it.
module stereo_allpass_biquad_cascade #(
    parameter int MAX_STAGES  = 8,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [SAMPLE_BITS-1:0]          s_left_in,
    input  logic signed [SAMPLE_BITS-1:0]          s_right_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [SAMPLE_BITS-1:0]          m_left_out,
    output logic signed [SAMPLE_BITS-1:0]          m_right_out,
    output logic                                   m_clipped,
    input  logic                                   cfg_we,
    input  logic [sapb_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [sapb_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import sapb_pkg::*;

    localparam int STG_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    logic signed [COEF_BITS-1:0]  coef_a0_reg, coef_a1_reg;
    logic [STAGE_CNT_BITS-1:0]    stage_count_reg;
    logic [STG_W-1:0]             stage_idx;
    sapb_cmd_t                    cmd;
    sapb_sts_t                    sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a0_reg     <= COEF_BITS'(4117380);
            coef_a1_reg     <= -COEF_BITS'(8311107);
            stage_count_reg <= STAGE_CNT_BITS'(1);
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_COEF_A0:     coef_a0_reg     <= cfg_data[COEF_BITS-1:0];
                CFG_COEF_A1:     coef_a1_reg     <= cfg_data[COEF_BITS-1:0];
                CFG_STAGE_COUNT: stage_count_reg <= cfg_data[STAGE_CNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    sapb_ctrl #(
        .MAX_STAGES (MAX_STAGES),
        .STG_W      (STG_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .stage_count (stage_count_reg),
        .stage_idx   (stage_idx),
        .cmd         (cmd),
        .sts         (sts)
    );

    sapb_dp #(
        .MAX_STAGES  (MAX_STAGES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .STG_W       (STG_W)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .stage_idx   (stage_idx),
        .coef_a0     (coef_a0_reg),
        .coef_a1     (coef_a1_reg),
        .s_left_in   (s_left_in),
        .s_right_in  (s_right_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out),
        .m_clipped   (m_clipped)
    );

endmodule
